[rtl/skn_pkg.sv]
// ----------------------------------------------------------------------------
// skn_pkg
// Shared types and constants of the sort key normalizer: byte codes, mode and
// register codes, and the command word passed from front to back.
// ----------------------------------------------------------------------------
package skn_pkg;

    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [1:0] REG_SKIP = 2'd0;
    localparam logic [1:0] REG_FOLD = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    typedef enum logic [1:0] {
        MODE_COPY    = 2'd0,
        MODE_PRINT   = 2'd1,
        MODE_DICT    = 2'd2,
        MODE_NUMERIC = 2'd3
    } skn_mode_t;

    typedef struct packed {
        logic             pre_en;
        logic [7:0]       pre_ch;
        logic             flush_en;
        logic [CNT_W-1:0] flush_cnt;
        logic             dot_en;
        logic [CNT_W-1:0] zeros_cnt;
        logic             post_en;
        logic [7:0]       post_ch;
        logic             term_en;
        logic             ovf;
    } skn_cmd_t;

endpackage

[rtl/skn_front.sv]
// ----------------------------------------------------------------------------
// skn_front
// Accepts key bytes, holds configuration and per-key state, buffers integer
// digits, and issues one command word per item that yields results.
// ----------------------------------------------------------------------------
module skn_front #(
    parameter int MAX_INT_DIGITS = 16,
    parameter int ZERO_RUN_MAX   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [1:0]                          cfg_wdata,
    output skn_pkg::skn_cmd_t                   cmd,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  logic                                flush_done,
    input  logic [$clog2(MAX_INT_DIGITS)-1:0]   rd_idx,
    output logic [3:0]                          rd_digit
);
    import skn_pkg::*;

    localparam int DIG_IDX_W = $clog2(MAX_INT_DIGITS);
    localparam int IC_W      = $clog2(MAX_INT_DIGITS + 1);
    localparam int ZR_W      = $clog2(ZERO_RUN_MAX + 1);

    typedef enum logic [1:0] {
        PH_SIGN = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    logic            skip_reg;
    logic            fold_reg;
    skn_mode_t       mode_reg;

    logic            at_start_reg, at_start_next;
    phase_t          phase_reg, phase_next;
    logic [IC_W-1:0] int_count_reg, int_count_next;
    logic [ZR_W-1:0] zero_run_reg, zero_run_next;
    logic            dot_reg, dot_next;
    logic            dropped_reg, dropped_next;
    logic            flush_wait_reg;

    logic [3:0]      digits_reg [MAX_INT_DIGITS];

    logic            accept;
    logic            dig_we;
    logic [7:0]      c;
    logic            is_digit, is_upper, is_lower;
    logic [7:0]      folded;
    skn_cmd_t        cmd_c;
    phase_t          eff_phase;

    assign cfg_ready = 1'b1;
    assign s_tready  = !flush_wait_reg && cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign c         = s_tdata;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_upper  = (c >= CH_UP_A) && (c <= CH_UP_Z);
    assign is_lower  = (c >= CH_LO_A) && (c <= CH_LO_Z);
    assign folded    = (fold_reg && is_upper) ? (c | CASE_BIT) : c;
    assign rd_digit  = digits_reg[rd_idx];
    assign cmd       = cmd_c;

    always_comb begin
        cmd_c          = '0;
        dig_we         = 1'b0;
        eff_phase      = phase_reg;
        at_start_next  = at_start_reg;
        phase_next     = phase_reg;
        int_count_next = int_count_reg;
        zero_run_next  = zero_run_reg;
        dot_next       = dot_reg;
        dropped_next   = dropped_reg;
        if (accept) begin
            if (s_tuser[0] == ACT_END) begin
                if (mode_reg == MODE_NUMERIC) begin
                    if (phase_reg == PH_SIGN) begin
                        cmd_c.pre_en = 1'b1;
                        cmd_c.pre_ch = CH_ZERO;
                    end
                    if (phase_reg == PH_SIGN || phase_reg == PH_INT) begin
                        cmd_c.flush_en  = 1'b1;
                        cmd_c.flush_cnt = CNT_W'(int_count_reg);
                    end
                end
                cmd_c.term_en  = 1'b1;
                cmd_c.ovf      = dropped_reg;
                at_start_next  = 1'b1;
                phase_next     = PH_SIGN;
                int_count_next = '0;
                zero_run_next  = '0;
                dot_next       = 1'b0;
                dropped_next   = 1'b0;
            end else if (!(at_start_reg && skip_reg && c <= CH_SPACE)) begin
                at_start_next = 1'b0;
                case (mode_reg)
                    MODE_COPY: begin
                        cmd_c.pre_en = 1'b1;
                        cmd_c.pre_ch = folded;
                    end
                    MODE_PRINT: begin
                        cmd_c.pre_en = (c >= CH_SPACE) && (c <= CH_TILDE);
                        cmd_c.pre_ch = folded;
                    end
                    MODE_DICT: begin
                        cmd_c.pre_en = is_digit || is_lower || is_upper || (c == CH_SPACE);
                        cmd_c.pre_ch = folded;
                    end
                    default: begin
                        if (phase_reg == PH_SIGN) begin
                            eff_phase    = PH_INT;
                            phase_next   = PH_INT;
                            cmd_c.pre_en = 1'b1;
                            cmd_c.pre_ch = (c == CH_MINUS) ? CH_MINUS : CH_ZERO;
                        end
                        if (!(phase_reg == PH_SIGN && c == CH_MINUS)) begin
                            if (eff_phase == PH_INT) begin
                                if (is_digit) begin
                                    if (int_count_reg < IC_W'(MAX_INT_DIGITS)) begin
                                        dig_we         = 1'b1;
                                        int_count_next = int_count_reg + 1'b1;
                                    end else begin
                                        dropped_next = 1'b1;
                                    end
                                end else begin
                                    cmd_c.flush_en  = 1'b1;
                                    cmd_c.flush_cnt = CNT_W'(int_count_reg);
                                    int_count_next  = '0;
                                    if (c == CH_DOT) begin
                                        dot_next      = 1'b1;
                                        zero_run_next = '0;
                                        phase_next    = PH_FRAC;
                                    end else begin
                                        phase_next = PH_DONE;
                                    end
                                end
                            end else if (eff_phase == PH_FRAC) begin
                                if (c == CH_ZERO) begin
                                    if (zero_run_reg < ZR_W'(ZERO_RUN_MAX)) begin
                                        zero_run_next = zero_run_reg + 1'b1;
                                    end else begin
                                        dropped_next = 1'b1;
                                    end
                                end else if (is_digit) begin
                                    cmd_c.dot_en    = dot_reg;
                                    cmd_c.zeros_cnt = CNT_W'(zero_run_reg);
                                    cmd_c.post_en   = 1'b1;
                                    cmd_c.post_ch   = c;
                                    dot_next        = 1'b0;
                                    zero_run_next   = '0;
                                end else begin
                                    zero_run_next = '0;
                                    dot_next      = 1'b0;
                                    phase_next    = PH_DONE;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign cmd_valid = cmd_c.pre_en || cmd_c.flush_en || cmd_c.dot_en
                    || cmd_c.post_en || cmd_c.term_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg       <= 1'b0;
            fold_reg       <= 1'b0;
            mode_reg       <= MODE_COPY;
            at_start_reg   <= 1'b1;
            phase_reg      <= PH_SIGN;
            int_count_reg  <= '0;
            zero_run_reg   <= '0;
            dot_reg        <= 1'b0;
            dropped_reg    <= 1'b0;
            flush_wait_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SKIP: skip_reg <= cfg_wdata[0];
                    REG_FOLD: fold_reg <= cfg_wdata[0];
                    REG_MODE: mode_reg <= skn_mode_t'(cfg_wdata);
                    default: ;
                endcase
            end
            at_start_reg  <= at_start_next;
            phase_reg     <= phase_next;
            int_count_reg <= int_count_next;
            zero_run_reg  <= zero_run_next;
            dot_reg       <= dot_next;
            dropped_reg   <= dropped_next;
            if (cmd_valid && cmd_c.flush_en) begin
                flush_wait_reg <= 1'b1;
            end else if (flush_done) begin
                flush_wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dig_we) begin
            digits_reg[int_count_reg[DIG_IDX_W-1:0]] <= c[3:0];
        end
    end

`ifndef ASSERT_OFF
    a_int_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int_count_reg <= IC_W'(MAX_INT_DIGITS))
        else $error("digit count beyond store depth");
    a_zero_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_run_reg <= ZR_W'(ZERO_RUN_MAX))
        else $error("zero run beyond limit");
    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_done |-> flush_wait_reg)
        else $error("flush done without a pending flush");
    a_wait_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_c.flush_en |=> flush_wait_reg && !s_tready)
        else $error("input not held during digit flush");
`endif

endmodule

[rtl/skn_queue.sv]
// ----------------------------------------------------------------------------
// skn_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module skn_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  skn_pkg::skn_cmd_t din,
    output logic              ready,
    input  logic              pop,
    output skn_pkg::skn_cmd_t dout,
    output logic              valid
);
    import skn_pkg::*;

    skn_cmd_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign ready = count_reg < (QPTR_W + 1)'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign dout  = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready)
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[rtl/skn_back.sv]
// ----------------------------------------------------------------------------
// skn_back
// Walks each command through its output steps (lead byte, pad zeros, stored
// digits, dot, fraction zeros and digit, terminator); at most one byte a cycle.
// ----------------------------------------------------------------------------
module skn_back #(
    parameter int PAD_WIDTH      = 9,
    parameter int MAX_INT_DIGITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  skn_pkg::skn_cmd_t                  cmd_in,
    input  logic                               cmd_valid,
    output logic                               cmd_pop,
    output logic                               flush_done,
    output logic [$clog2(MAX_INT_DIGITS)-1:0]  rd_idx,
    input  logic [3:0]                         rd_digit,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast,
    output logic [0:0]                         m_tuser
);
    import skn_pkg::*;

    localparam int DIG_IDX_W = $clog2(MAX_INT_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_PRE  = 3'd1,
        ST_PAD  = 3'd2,
        ST_DIG  = 3'd3,
        ST_DOT  = 3'd4,
        ST_ZERO = 3'd5,
        ST_POST = 3'd6,
        ST_TERM = 3'd7
    } stage_t;

    function automatic logic [CNT_W-1:0] pad_of(skn_cmd_t cw);
        logic [CNT_W-1:0] r;
        r = '0;
        if (cw.flush_en && cw.flush_cnt < CNT_W'(PAD_WIDTH)) begin
            r = CNT_W'(PAD_WIDTH) - cw.flush_cnt;
        end
        return r;
    endfunction

    function automatic stage_t stage_after(stage_t from, skn_cmd_t cw);
        stage_t r;
        r = ST_IDLE;
        if (cw.term_en && from < ST_TERM) r = ST_TERM;
        if (cw.post_en && from < ST_POST) r = ST_POST;
        if (cw.zeros_cnt != '0 && from < ST_ZERO) r = ST_ZERO;
        if (cw.dot_en && from < ST_DOT) r = ST_DOT;
        if (cw.flush_en && cw.flush_cnt != '0 && from < ST_DIG) r = ST_DIG;
        if (pad_of(cw) != '0 && from < ST_PAD) r = ST_PAD;
        if (cw.pre_en && from < ST_PRE) r = ST_PRE;
        return r;
    endfunction

    stage_t           stage_reg, stage_next;
    skn_cmd_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             out_free;
    logic             adv;
    stage_t           after;

    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_idx   = idx_reg[DIG_IDX_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        stage_next    = stage_reg;
        cmd_next      = cmd_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        adv           = 1'b0;
        cmd_pop       = 1'b0;
        flush_done    = 1'b0;
        if (out_free) begin
            case (stage_reg)
                ST_PRE: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cmd_reg.pre_ch;
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b0;
                    adv           = 1'b1;
                end
                ST_PAD, ST_ZERO: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_ZERO;
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b0;
                    cnt_next      = cnt_reg - 1'b1;
                    adv           = (cnt_reg == CNT_W'(1));
                end
                ST_DIG: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_ZERO | {4'h0, rd_digit};
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b0;
                    idx_next      = idx_reg + 1'b1;
                    adv           = (idx_reg + 1'b1 == cmd_reg.flush_cnt);
                end
                ST_DOT: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_DOT;
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b0;
                    adv           = 1'b1;
                end
                ST_POST: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cmd_reg.post_ch;
                    m_tlast_next  = 1'b0;
                    m_tuser_next  = 1'b0;
                    adv           = 1'b1;
                end
                ST_TERM: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_NUL;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = cmd_reg.ovf;
                    adv           = 1'b1;
                end
                default: ;
            endcase
        end
        after = stage_after(stage_reg, cmd_reg);
        if (adv) begin
            stage_next = after;
            if (cmd_reg.flush_en && (stage_reg == ST_DIG
                || (stage_reg == ST_PAD && after != ST_DIG))) begin
                flush_done = 1'b1;
            end
        end
        if ((stage_reg == ST_IDLE || (adv && after == ST_IDLE)) && cmd_valid) begin
            cmd_pop    = 1'b1;
            cmd_next   = cmd_in;
            stage_next = stage_after(ST_IDLE, cmd_in);
        end
        if (adv || cmd_pop) begin
            if (stage_next == ST_PAD) cnt_next = pad_of(cmd_next);
            if (stage_next == ST_ZERO) cnt_next = cmd_next.zeros_cnt;
            if (stage_next == ST_DIG) idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            stage_reg    <= stage_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef ASSERT_OFF
    a_dig_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg == ST_DIG |-> idx_reg < cmd_reg.flush_cnt)
        else $error("digit index past flush count");
    a_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == ST_PAD || stage_reg == ST_ZERO) |-> cnt_reg != '0)
        else $error("empty zero run in progress");
    a_last_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tdata_reg == CH_NUL)
        else $error("terminator carries a nonzero byte");
    a_flag_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg |-> m_tlast_reg)
        else $error("overflow flag off the terminator");
`endif

endmodule

[rtl/sort_key_normalizer.sv]
// ----------------------------------------------------------------------------
// sort_key_normalizer
// Rewrites the bytes of a key into a byte-comparable sort key (copy,
// printable, dictionary or numeric mode, optional blank skip and case fold).
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata: in_char; s_tuser: action
//   m_       out  m_tvalid/m_tready   m_tdata: out_char; m_tlast: last;
//                                     m_tuser: overflow
//   cfg_     in   cfg_valid/cfg_ready cfg_index: register; cfg_wdata: value
//
// Outside numeric flushes one result leaves per cycle; copy mode keeps one
// byte a cycle. A number flush emits PAD_WIDTH or more bytes, one a cycle
// from the digit buffer, and input waits until the buffer is read out.
// A back-pressured output stalls the sequencer; the two-entry command queue
// lets input run on meanwhile. Reset is synchronous.
// ----------------------------------------------------------------------------
module sort_key_normalizer #(
    parameter int PAD_WIDTH      = 9,
    parameter int MAX_INT_DIGITS = 16,
    parameter int ZERO_RUN_MAX   = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic [0:0] s_tuser,    // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast,
    output logic [0:0] m_tuser,    // [0] overflow
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_wdata
);
    import skn_pkg::*;

    localparam int DIG_IDX_W = $clog2(MAX_INT_DIGITS);

    skn_cmd_t             f_cmd;
    logic                 f_cmd_valid;
    logic                 q_ready;
    skn_cmd_t             q_cmd;
    logic                 q_valid;
    logic                 b_pop;
    logic                 flush_done;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [3:0]           rd_digit;

    skn_front #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS),
        .ZERO_RUN_MAX   (ZERO_RUN_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (f_cmd),
        .cmd_valid  (f_cmd_valid),
        .cmd_ready  (q_ready),
        .flush_done (flush_done),
        .rd_idx     (rd_idx),
        .rd_digit   (rd_digit)
    );

    skn_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_cmd_valid),
        .din     (f_cmd),
        .ready   (q_ready),
        .pop     (b_pop),
        .dout    (q_cmd),
        .valid   (q_valid)
    );

    skn_back #(
        .PAD_WIDTH      (PAD_WIDTH),
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_in     (q_cmd),
        .cmd_valid  (q_valid),
        .cmd_pop    (b_pop),
        .flush_done (flush_done),
        .rd_idx     (rd_idx),
        .rd_digit   (rd_digit),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
